>>> sv/hsv_pkg.sv
`default_nettype none

package hsv_pkg;

	// hue sector constants, in degrees
	localparam logic [8:0] HSV_DEG_60  = 9'd60;
	localparam logic [8:0] HSV_DEG_120 = 9'd120;
	localparam logic [8:0] HSV_DEG_240 = 9'd240;
	localparam logic [8:0] HSV_DEG_360 = 9'd360;
	localparam logic [7:0] HSV_FULL8   = 8'd255;

	// one quotient bit per divider stage, nine bits cover hue 0..360
	localparam int HSV_DIV_STAGES = 9;

	// floor(y / 45) = (y * HSV_RECIP) >> HSV_RECIP_SHIFT for y < 2**22
	localparam logic [22:0] HSV_RECIP       = 23'd5965233;
	localparam int          HSV_RECIP_SHIFT = 28;

	// which channel is largest, ties go to red then green
	typedef enum logic [2:0] {
		SEL_RED   = 3'b001,
		SEL_GREEN = 3'b010,
		SEL_BLUE  = 3'b100
	} hsv_sel_t;

	// state of one restoring division in flight
	typedef struct packed {
		logic [7:0] rem;
		logic [8:0] quo;
		logic [7:0] den;
	} hsv_div_t;

	// one slot of the divider pipeline; sat.den carries the brightness
	typedef struct packed {
		logic     valid;
		hsv_div_t hue;
		hsv_div_t sat;
	} hsv_stage_t;

	typedef struct packed {
		logic [8:0]  hue_degrees;
		logic [15:0] hue_scaled;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_result_t;

	// one shift-compare-subtract step, remainder stays below the divisor
	function automatic hsv_div_t div_step(hsv_div_t x);
		logic [8:0] trial;
		hsv_div_t   y;
		trial = {x.rem, x.quo[8]};
		y     = x;
		if (trial >= {1'b0, x.den}) begin
			y.rem = 8'(trial - {1'b0, x.den});
			y.quo = {x.quo[7:0], 1'b1};
		end else begin
			y.rem = trial[7:0];
			y.quo = {x.quo[7:0], 1'b0};
		end
		return y;
	endfunction

endpackage

`default_nettype wire

>>> sv/hsv_prep.sv
`default_nettype none

module hsv_prep (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               pixel_valid,
	input  wire logic [7:0]         red,
	input  wire logic [7:0]         green,
	input  wire logic [7:0]         blue,
	output hsv_pkg::hsv_stage_t     prep
);
	import hsv_pkg::*;

	logic [7:0] mx;
	logic [7:0] mn;
	logic [7:0] op_a;
	logic [7:0] op_b;
	hsv_sel_t   sel;

	logic       valid_s1;
	logic [7:0] delta_s1;
	logic [7:0] max_s1;
	logic [7:0] k_s1;
	logic       neg_s1;
	hsv_sel_t   sel_s1;

	logic [8:0]  base;
	logic [16:0] base_term;
	logic [16:0] slope_term;
	logic [16:0] hue_num;
	logic [16:0] sat_num;

	logic        valid_s2;
	hsv_div_t    hue_s2;
	hsv_div_t    sat_s2;

	// stage 1: extremes, dominant channel and the signed channel difference
	always_comb begin
		mx = red;
		if (green > mx) mx = green;
		if (blue > mx) mx = blue;
		mn = red;
		if (green < mn) mn = green;
		if (blue < mn) mn = blue;
		if (mx == red) begin
			sel  = SEL_RED;
			op_a = green;
			op_b = blue;
		end else if (mx == green) begin
			sel  = SEL_GREEN;
			op_a = blue;
			op_b = red;
		end else begin
			sel  = SEL_BLUE;
			op_a = red;
			op_b = green;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pixel_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s1 <= mx - mn;
			max_s1   <= mx;
			sel_s1   <= sel;
			neg_s1   <= op_a < op_b;
			k_s1     <= (op_a >= op_b) ? op_a - op_b : op_b - op_a;
		end
	end

	// stage 2: hue numerator base*d +/- 60*k and saturation numerator d*255
	always_comb begin
		unique case (sel_s1)
			SEL_RED:   base = neg_s1 ? HSV_DEG_360 : 9'd0;
			SEL_GREEN: base = HSV_DEG_120;
			SEL_BLUE:  base = HSV_DEG_240;
			default:   base = 9'd0;
		endcase
		base_term  = 17'(base) * 17'(delta_s1);
		slope_term = 17'(HSV_DEG_60) * 17'(k_s1);
		hue_num    = neg_s1 ? base_term - slope_term : base_term + slope_term;
		sat_num    = 17'(delta_s1) * 17'(HSV_FULL8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hue_s2.rem <= hue_num[16:9];
			hue_s2.quo <= hue_num[8:0];
			hue_s2.den <= delta_s1;
			sat_s2.rem <= sat_num[16:9];
			sat_s2.quo <= sat_num[8:0];
			sat_s2.den <= max_s1;
		end
	end

	assign prep = {valid_s2, hue_s2, sat_s2};

endmodule

`default_nettype wire

>>> sv/hsv_div_stage.sv
`default_nettype none

module hsv_div_stage (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  hsv_pkg::hsv_stage_t  stage_in,
	output hsv_pkg::hsv_stage_t  stage_out
);
	import hsv_pkg::*;

	logic     valid_s1;
	hsv_div_t hue_s1;
	hsv_div_t sat_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= stage_in.valid;
		end
	end

	// hue and saturation each retire one quotient bit
	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1 <= div_step(stage_in.hue);
			sat_s1 <= div_step(stage_in.sat);
		end
	end

	assign stage_out = {valid_s1, hue_s1, sat_s1};

endmodule

`default_nettype wire

>>> sv/hsv_scale.sv
`default_nettype none

module hsv_scale (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  hsv_pkg::hsv_stage_t  quot,
	output logic                 res_valid,
	output hsv_pkg::hsv_result_t res
);
	import hsv_pkg::*;

	logic [8:0]  hue;
	logic [24:0] hue_x65535;

	logic        valid_s1;
	logic [8:0]  hue_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  bright_s1;
	logic [21:0] eighth_s1;

	logic        valid_s2;
	logic [8:0]  hue_s2;
	logic [7:0]  sat_s2;
	logic [7:0]  bright_s2;
	logic [44:0] prod_s2;

	// grey gives hue 0, black gives saturation 0
	always_comb begin
		if (quot.hue.den == 8'd0) begin
			hue = 9'd0;
		end else if (quot.hue.quo >= HSV_DEG_360) begin
			hue = quot.hue.quo - HSV_DEG_360;
		end else begin
			hue = quot.hue.quo;
		end
		hue_x65535 = (25'(hue) << 16) - 25'(hue);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= quot.valid;
			valid_s2 <= valid_s1;
		end
	end

	// x/360 = (x>>3)/45, the /45 by reciprocal multiply
	always_ff @(posedge clk) begin
		if (en) begin
			hue_s1    <= hue;
			sat_s1    <= (quot.sat.den == 8'd0) ? 8'd0 : quot.sat.quo[7:0];
			bright_s1 <= quot.sat.den;
			eighth_s1 <= hue_x65535[24:3];
			hue_s2    <= hue_s1;
			sat_s2    <= sat_s1;
			bright_s2 <= bright_s1;
			prod_s2   <= 45'(eighth_s1) * 45'(HSV_RECIP);
		end
	end

	assign res_valid       = valid_s2;
	assign res.hue_degrees = hue_s2;
	assign res.hue_scaled  = prod_s2[HSV_RECIP_SHIFT +: 16];
	assign res.saturation  = sat_s2;
	assign res.brightness  = bright_s2;

endmodule

`default_nettype wire

>>> sv/rgb_to_hsv_pixel_top.sv
// 8-bit RGB to HSV pixel converter. Each pixel transaction (red, green, blue)
// yields one result transaction: brightness is the largest channel,
// saturation is floor((max-min)*255/max) and 0 for black, hue_degrees is the
// truncated hue 0..359 and 0 for grey, and hue_scaled is
// floor(hue_degrees*65535/360). The block takes one pixel every clock while
// pixel_stall is low. Each pixel passes through operand preparation, a
// radix-2 restoring divider that retires one quotient bit per stage for hue
// and saturation side by side, the hue scaling multiply, and the output
// register. A two-entry output buffer lets the pipeline keep moving while one
// result waits; pixel_stall rises only once both entries are full.
`default_nettype none

module rgb_to_hsv_pixel_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// pixel transaction
	input  wire logic       pixel_valid,
	output logic            pixel_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	// result transaction
	output logic            hsv_valid,
	input  wire logic       hsv_stall,
	output logic [8:0]      hue_degrees,
	output logic [15:0]     hue_scaled,
	output logic [7:0]      saturation,
	output logic [7:0]      brightness
);
	import hsv_pkg::*;

	// whole pipeline advances together; it freezes only when the skid entry is full
	logic        en;
	hsv_stage_t  div_pipe [0:HSV_DIV_STAGES];
	logic        res_valid;
	hsv_result_t res;

	// output register and skid entry
	logic        out_valid_q;
	hsv_result_t out_q;
	logic        skid_valid_q;
	hsv_result_t skid_q;
	logic        out_free;

	assign en          = !skid_valid_q;
	assign pixel_stall = skid_valid_q;

	// max/min, sector select, numerators
	hsv_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.pixel_valid (pixel_valid),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.prep        (div_pipe[0])
	);

	// one quotient bit per stage
	for (genvar i = 0; i < HSV_DIV_STAGES; i++) begin : g_div
		hsv_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.stage_in  (div_pipe[i]),
			.stage_out (div_pipe[i+1])
		);
	end

	// special cases and hue scaling
	hsv_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.quot      (div_pipe[HSV_DIV_STAGES]),
		.res_valid (res_valid),
		.res       (res)
	);

	// output register is free when empty or being taken this cycle
	assign out_free = !out_valid_q || !hsv_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid && !skid_valid_q) begin
			// result arrives while the output waits: park it
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (!skid_valid_q) begin
			skid_q <= res;
		end
	end

	assign hsv_valid   = out_valid_q;
	assign hue_degrees = out_q.hue_degrees;
	assign hue_scaled  = out_q.hue_scaled;
	assign saturation  = out_q.saturation;
	assign brightness  = out_q.brightness;

`ifndef SYNTHESIS
	// the skid entry only fills behind a held output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry full while output register empty");

	// hue stays within one turn
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid |-> (hue_degrees < 9'd360))
		else $error("hue out of range");

	// zero saturation means a grey pixel, whose hue is zero
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && saturation == 8'd0) |-> (hue_degrees == 9'd0))
		else $error("grey pixel with nonzero hue");

	// scaled hue follows degrees
	a_scaled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hue_degrees == 9'd0) |-> (hue_scaled == 16'd0))
		else $error("scaled hue nonzero for zero hue");
`endif

endmodule

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;
	import hsv_pkg::*;

	typedef struct {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// pixel transaction, driven by the bench
	logic       pixel_valid = 1'b0;
	logic       pixel_stall;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;

	// result transaction, sampled by the bench
	logic        hsv_valid;
	logic        hsv_stall = 1'b0;
	logic [8:0]  hue_degrees;
	logic [15:0] hue_scaled;
	logic [7:0]  saturation;
	logic [7:0]  brightness;

	// pixels waiting to be driven, and predicted results in arrival order
	pixel_t      pixel_q[$];
	hsv_result_t hsv_exp_q[$];
	pixel_t      next_pixel;
	hsv_result_t got_hsv;
	hsv_result_t want_hsv;

	// idle percentages for sender and receiver, changed per phase
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int pixels_sent = 0;
	int results_checked = 0;
	int directed_count = 0;
	int fail_count = 0;
	int mismatch_count = 0;

	rgb_to_hsv_pixel_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.red         (red),
		.green       (green),
		.blue        (blue),
		.hsv_valid   (hsv_valid),
		.hsv_stall   (hsv_stall),
		.hue_degrees (hue_degrees),
		.hue_scaled  (hue_scaled),
		.saturation  (saturation),
		.brightness  (brightness)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// exact integer hsv of one pixel
	function automatic hsv_result_t predict_hsv(logic [7:0] r8, logic [7:0] g8, logic [7:0] b8);
		int unsigned r, g, b, mx, mn, d, num, hue;
		hsv_result_t res;
		r = r8;
		g = g8;
		b = b8;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		d = mx - mn;
		if (d == 0) begin
			// grey, hue is zero
			hue = 0;
		end else begin
			// ties go to red, then green
			if (mx == r) begin
				if (g >= b) num = 60 * (g - b);
				else num = 360 * d - 60 * (b - g);
			end else if (mx == g) begin
				if (b >= r) num = 120 * d + 60 * (b - r);
				else num = 120 * d - 60 * (r - b);
			end else begin
				if (r >= g) num = 240 * d + 60 * (r - g);
				else num = 240 * d - 60 * (g - r);
			end
			hue = (num / d) % 360;
		end
		res.hue_degrees = 9'(hue);
		res.hue_scaled  = 16'((hue * 65535) / 360);
		// black has no saturation
		res.saturation  = (mx == 0) ? 8'd0 : 8'((d * 255) / mx);
		res.brightness  = 8'(mx);
		return res;
	endfunction

	function automatic logic [7:0] clamp8(int v);
		if (v < 0) return 8'd0;
		if (v > 255) return 8'd255;
		return 8'(v);
	endfunction

	// random pixel, biased toward greys, near greys, ties and the rails
	function automatic pixel_t random_pixel();
		pixel_t p;
		logic [7:0] ch[3];
		int base, k, v;
		case ($urandom_range(9))
			5: begin
				base = $urandom_range(255);
				for (k = 0; k < 3; k++) ch[k] = clamp8(base + int'($urandom_range(4)) - 2);
			end
			6: begin
				v = $urandom_range(255);
				for (k = 0; k < 3; k++) ch[k] = 8'(v);
				ch[$urandom_range(2)] = 8'($urandom_range(v));
			end
			7: begin
				for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(255));
				ch[$urandom_range(2)] = $urandom_range(1) ? 8'd255 : 8'd0;
			end
			8: begin
				for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(3));
			end
			9: begin
				v = $urandom_range(255);
				for (k = 0; k < 3; k++) ch[k] = 8'(v);
			end
			default: begin
				for (k = 0; k < 3; k++) ch[k] = 8'($urandom_range(255));
			end
		endcase
		p.r = ch[0];
		p.g = ch[1];
		p.b = ch[2];
		return p;
	endfunction

	task automatic add_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pixel_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		pixel_q.push_back(p);
	endtask

	// hold the sender until every queued pixel has its result back
	task automatic wait_drained();
		while (pixel_q.size() != 0 || pixel_valid || hsv_exp_q.size() != 0) @(posedge clk);
	endtask

	// pixel driver: predict on acceptance, then present the next pixel or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
			red <= 8'd0;
			green <= 8'd0;
			blue <= 8'd0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				hsv_exp_q.push_back(predict_hsv(red, green, blue));
				pixels_sent++;
			end
			// a stalled transaction keeps its payload
			if (!pixel_valid || !pixel_stall) begin
				if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_pixel = pixel_q.pop_front();
					pixel_valid <= 1'b1;
					red <= next_pixel.r;
					green <= next_pixel.g;
					blue <= next_pixel.b;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare against the oldest prediction, then pick the stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_stall <= 1'b0;
		end else begin
			if (hsv_valid && !hsv_stall) begin
				got_hsv.hue_degrees = hue_degrees;
				got_hsv.hue_scaled  = hue_scaled;
				got_hsv.saturation  = saturation;
				got_hsv.brightness  = brightness;
				if (hsv_exp_q.size() == 0) begin
					fail_count++;
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result transaction: hue %0d scaled %0d sat %0d val %0d",
							hue_degrees, hue_scaled, saturation, brightness);
				end else begin
					want_hsv = hsv_exp_q.pop_front();
					results_checked++;
					if (got_hsv != want_hsv) begin
						fail_count++;
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result %0d mismatch: exp hue %0d scaled %0d sat %0d val %0d, got hue %0d scaled %0d sat %0d val %0d",
								results_checked, want_hsv.hue_degrees, want_hsv.hue_scaled,
								want_hsv.saturation, want_hsv.brightness, got_hsv.hue_degrees,
								got_hsv.hue_scaled, got_hsv.saturation, got_hsv.brightness);
					end
				end
			end
			hsv_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// stimulus and end of run
	initial begin
		int n;
		pixel_t p;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// phase one: sender rarely idles, receiver stalls most cycles
		send_idle_pct = 6;
		recv_idle_pct = 86;

		// directed pixels
		add_pixel(8'd0, 8'd0, 8'd0);       // black
		add_pixel(8'd255, 8'd255, 8'd255); // white
		add_pixel(8'd128, 8'd128, 8'd128); // mid grey
		add_pixel(8'd1, 8'd1, 8'd1);       // darkest grey
		add_pixel(8'd255, 8'd0, 8'd0);     // pure red
		add_pixel(8'd0, 8'd255, 8'd0);     // pure green
		add_pixel(8'd0, 8'd0, 8'd255);     // pure blue
		add_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
		add_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
		add_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
		add_pixel(8'd255, 8'd0, 8'd1);     // red sector, hue wraps just below 360
		add_pixel(8'd255, 8'd0, 8'd128);   // red sector, wrapped
		add_pixel(8'd0, 8'd200, 8'd100);   // green sector, blue above red
		add_pixel(8'd100, 8'd200, 8'd0);   // green sector, red above blue
		add_pixel(8'd200, 8'd0, 8'd100);   // blue below red, wrapped
		add_pixel(8'd100, 8'd0, 8'd200);   // blue sector, red above green
		add_pixel(8'd0, 8'd100, 8'd200);   // blue sector, green above red
		add_pixel(8'd1, 8'd0, 8'd0);       // smallest red
		add_pixel(8'd0, 8'd1, 8'd0);       // smallest green
		add_pixel(8'd0, 8'd0, 8'd1);       // smallest blue
		add_pixel(8'd254, 8'd255, 8'd253); // near white
		add_pixel(8'd255, 8'd254, 8'd255); // red and blue tie, near white
		directed_count = pixel_q.size();

		for (n = 0; n < 630; n++) begin
			p = random_pixel();
			pixel_q.push_back(p);
		end
		// sender holds until the pipeline and output buffer are empty
		wait_drained();

		// phase two: sender idles most cycles, receiver rarely stalls
		send_idle_pct = 86;
		recv_idle_pct = 6;
		for (n = 0; n < 630; n++) begin
			p = random_pixel();
			pixel_q.push_back(p);
		end
		wait_drained();

		// phase three: full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (n = 0; n < 640; n++) begin
			p = random_pixel();
			pixel_q.push_back(p);
		end
		wait_drained();

		// let any stray result surface past the pipeline latency
		repeat (30) @(posedge clk);
		if (hsv_exp_q.size() != 0) fail_count++;

		$display("converted %0d pixel transactions (%0d directed) under three idle and stall mixes",
			pixels_sent, directed_count);
		$display("checked %0d result transactions, %0d mismatches", results_checked, mismatch_count);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", hsv_exp_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
